@@ rtl/core/eldf_pkg.sv @@
// Shared types and constants for the escaped length frame deframer.
`timescale 1ns / 1ps
`default_nettype none

package eldf_pkg;

    localparam logic [7:0]  MARK_BYTE  = 8'hFF;
    localparam logic [7:0]  STUFF_BYTE = 8'h55;
    localparam logic [15:0] HIGH_MASK  = 16'hFF00;

    // Frame phase codes; codes 5..7 are unused and behave as header hunt.
    typedef enum logic [2:0] {
        PH_HUNT1 = 3'd0,
        PH_HUNT2 = 3'd1,
        PH_LENHI = 3'd2,
        PH_LENLO = 3'd3,
        PH_BODY  = 3'd4
    } frame_phase_t;

    // Deframer state carried from byte to byte.
    typedef struct packed {
        frame_phase_t phase;
        logic         esc_pending;
        logic [15:0]  bytes_left;
    } dfr_state_t;

    // One result transfer.
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       discard;
    } frame_res_t;

endpackage : eldf_pkg

`default_nettype wire

@@ rtl/core/eldf_step.sv @@
// Per-byte next-state and result logic of the deframer.
`timescale 1ns / 1ps
`default_nettype none

module eldf_step
    import eldf_pkg::*;
(
    input  wire dfr_state_t  cur,
    input  wire logic [7:0]  rx_data,
    output dfr_state_t       nxt,
    output logic             emit,
    output frame_res_t       res
);

    logic        started;
    logic        go;
    logic [7:0]  data;
    logic [15:0] len_sum;
    logic [15:0] len_dec;

    // an escaped 0x55 stands for a data 0xFF
    assign data    = (cur.esc_pending && (rx_data == STUFF_BYTE)) ? MARK_BYTE : rx_data;
    assign len_sum = cur.bytes_left + {8'h00, data};
    assign len_dec = cur.bytes_left - 16'd1;

    always_comb
    begin
        nxt     = cur;
        emit    = 1'b0;
        res     = '0;
        started = 1'b0;
        go      = 1'b0;
        case (cur.phase)
            PH_HUNT2:
            begin
                nxt.phase = (rx_data == MARK_BYTE) ? PH_LENHI : PH_HUNT1;
            end
            PH_LENHI, PH_LENLO, PH_BODY:
            begin
                started = (cur.phase != PH_LENHI);
                go      = 1'b1;
                if (cur.esc_pending)
                begin
                    nxt.esc_pending = 1'b0;
                    if (rx_data == STUFF_BYTE)
                    begin
                        // stuffed pair: data already carries 0xFF
                        go = 1'b1;
                    end
                    else if (rx_data == MARK_BYTE)
                    begin
                        // new header inside a frame: restart at length
                        nxt.phase   = PH_LENHI;
                        go          = 1'b0;
                        emit        = started;
                        res.discard = 1'b1;
                    end
                    else if (started)
                    begin
                        nxt.phase   = PH_HUNT1;
                        go          = 1'b0;
                        emit        = 1'b1;
                        res.discard = 1'b1;
                    end
                end
                else if (rx_data == MARK_BYTE)
                begin
                    nxt.esc_pending = 1'b1;
                    go              = 1'b0;
                end

                if (go)
                begin
                    case (cur.phase)
                        PH_LENHI:
                        begin
                            nxt.bytes_left = {data, 8'h00} & HIGH_MASK;
                            nxt.phase      = PH_LENLO;
                            emit           = 1'b1;
                            res.data       = data;
                            res.first      = 1'b1;
                        end
                        PH_LENLO:
                        begin
                            nxt.bytes_left = len_sum;
                            emit           = 1'b1;
                            if (len_sum == 16'd0)
                            begin
                                nxt.phase   = PH_HUNT1;
                                res.discard = 1'b1;
                            end
                            else
                            begin
                                nxt.phase = PH_BODY;
                                res.data  = data;
                            end
                        end
                        default:
                        begin
                            nxt.bytes_left = len_dec;
                            emit           = 1'b1;
                            res.data       = data;
                            if (len_dec == 16'd0)
                            begin
                                nxt.phase = PH_HUNT1;
                                res.last  = 1'b1;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                nxt.phase = (rx_data == MARK_BYTE) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
    end

endmodule : eldf_step

`default_nettype wire

@@ rtl/core/eldf_out_reg.sv @@
// Result register holding one frame transfer for the downstream side.
`timescale 1ns / 1ps
`default_nettype none

module eldf_out_reg
    import eldf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       load,
    input  wire frame_res_t load_res,
    input  wire logic       out_stall,
    output logic            out_free,
    output logic            out_valid,
    output frame_res_t      out_res
);

    logic       valid_reg;
    logic       valid_next;
    frame_res_t res_reg;

    // free when empty or draining this cycle
    assign out_free   = !valid_reg || !out_stall;
    assign valid_next = load || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= load_res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule : eldf_out_reg

`default_nettype wire

@@ rtl/core/escaped_length_frame_deframer_unit.sv @@
// Top level of the escaped length-prefixed frame deframer.
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  rx      | rx_valid / rx_stall    | rx_byte[7:0]
//  frame   | frame_valid/frame_stall| frame_byte[7:0], first_byte, last_byte,
//          |                        | discard
//
//  One byte per cycle sustained while the result register is not stalled.
//  A byte is captured in the input register, then the phase/escape/length
//  state and the result register are updated from it as it retires.
//  Bytes that give no result (header hunt, escape mark) retire even while
//  the result register is stalled. rst_n clears the phase to header hunt,
//  the escape flag, the length count and both valid flags.
//  rx_stall rises only when the held byte has a result and the result
//  register cannot take it.
`timescale 1ns / 1ps
`default_nettype none

module escaped_length_frame_deframer_unit
    import eldf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       rx_valid,
    output logic            rx_stall,
    input  wire logic [7:0] rx_byte,
    output logic            frame_valid,
    input  wire logic       frame_stall,
    output logic [7:0]      frame_byte,
    output logic            first_byte,
    output logic            last_byte,
    output logic            discard
);

    // input register
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;

    // deframer state
    dfr_state_t state_reg;
    dfr_state_t state_next;

    logic       step_emit;
    frame_res_t step_res;
    logic       out_free;
    logic       advance;
    logic       rx_take;
    frame_res_t out_res;

    eldf_step u_step (
        .cur     (state_reg),
        .rx_data (in_byte_reg),
        .nxt     (state_next),
        .emit    (step_emit),
        .res     (step_res)
    );

    // held byte retires when it has no result or the result slot is free
    assign advance       = in_valid_reg && (!step_emit || out_free);
    assign rx_stall      = in_valid_reg && !advance;
    assign rx_take       = rx_valid && !rx_stall;
    assign in_valid_next = rx_take || (in_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '{phase: PH_HUNT1, esc_pending: 1'b0, bytes_left: 16'd0};
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    eldf_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && step_emit),
        .load_res  (step_res),
        .out_stall (frame_stall),
        .out_free  (out_free),
        .out_valid (frame_valid),
        .out_res   (out_res)
    );

    assign frame_byte = out_res.data;
    assign first_byte = out_res.first;
    assign last_byte  = out_res.last;
    assign discard    = out_res.discard;

endmodule : escaped_length_frame_deframer_unit

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the escaped length frame deframer.
`timescale 1ns / 1ps

module tb;
    import eldf_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 8;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       rx_valid = 1'b0;
    logic       rx_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       frame_valid;
    logic       frame_stall = 1'b0;
    logic [7:0] frame_byte;
    logic       first_byte;
    logic       last_byte;
    logic       discard;

    // Raw link bytes waiting to go out, and frame transfers still owed by the block.
    logic [7:0] pending_bytes[$];
    frame_res_t expected_frames[$];

    // Idle rates in percent, changed only while the block is drained.
    int unsigned send_idle_pct = 25;
    int unsigned recv_stall_pct = 71;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    // Predicted deframer state; this matches the block's state after reset.
    frame_phase_t dfr_phase = PH_HUNT1;
    logic         dfr_esc = 1'b0;
    logic [15:0]  dfr_left = 16'h0000;

    escaped_length_frame_deframer_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_valid    (rx_valid),
        .rx_stall    (rx_stall),
        .rx_byte     (rx_byte),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame_byte  (frame_byte),
        .first_byte  (first_byte),
        .last_byte   (last_byte),
        .discard     (discard)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Advance the predicted state by one raw byte; queue the frame transfer it causes.
    task automatic deframe_byte(input logic [7:0] raw);
        logic [7:0] b;
        frame_res_t res;
        logic       emit;
        logic       take;
        logic       started;
        b = raw;
        res = '0;
        emit = 1'b0;
        take = 1'b1;
        if (dfr_phase == PH_HUNT2)
        begin
            dfr_phase = (b == MARK_BYTE) ? PH_LENHI : PH_HUNT1;
        end
        else if (dfr_phase != PH_LENHI && dfr_phase != PH_LENLO && dfr_phase != PH_BODY)
        begin
            dfr_phase = (b == MARK_BYTE) ? PH_HUNT2 : PH_HUNT1;
        end
        else
        begin
            // Length bytes already out means the frame has started.
            started = (dfr_phase != PH_LENHI);
            if (dfr_esc)
            begin
                dfr_esc = 1'b0;
                if (b == STUFF_BYTE)
                begin
                    b = MARK_BYTE;
                end
                else if (b == MARK_BYTE)
                begin
                    // New header inside a frame: back to length high.
                    take = 1'b0;
                    emit = started;
                    res.discard = 1'b1;
                    dfr_phase = PH_LENHI;
                end
                else if (started)
                begin
                    take = 1'b0;
                    emit = 1'b1;
                    res.discard = 1'b1;
                    dfr_phase = PH_HUNT1;
                end
                // Otherwise the mark belonged to the header run; b is length high.
            end
            else if (b == MARK_BYTE)
            begin
                dfr_esc = 1'b1;
                take = 1'b0;
            end

            if (take)
            begin
                emit = 1'b1;
                case (dfr_phase)
                    PH_LENHI:
                    begin
                        dfr_left = ({8'h00, b} << 8) & HIGH_MASK;
                        dfr_phase = PH_LENLO;
                        res.data = b;
                        res.first = 1'b1;
                    end
                    PH_LENLO:
                    begin
                        dfr_left = dfr_left + {8'h00, b};
                        if (dfr_left == 16'h0000)
                        begin
                            // Zero length: discard instead of the low byte.
                            dfr_phase = PH_HUNT1;
                            res.discard = 1'b1;
                        end
                        else
                        begin
                            dfr_phase = PH_BODY;
                            res.data = b;
                        end
                    end
                    default:
                    begin
                        dfr_left = dfr_left - 16'd1;
                        res.data = b;
                        if (dfr_left == 16'h0000)
                        begin
                            res.last = 1'b1;
                            dfr_phase = PH_HUNT1;
                        end
                    end
                endcase
            end
        end
        if (emit)
            expected_frames.push_back(res);
    endtask

    // Driver: a new byte goes out only once the previous one has transferred.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_valid <= 1'b0;
            rx_byte  <= 8'h00;
        end
        else
        begin
            if (rx_valid && !rx_stall)
                deframe_byte(rx_byte);
            if (!rx_valid || !rx_stall)
            begin
                if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    rx_valid <= 1'b1;
                    rx_byte  <= pending_bytes.pop_front();
                end
                else
                begin
                    rx_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frame_stall <= 1'b0;
        else
            frame_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Monitor: each frame transfer is matched against the oldest expectation.
    always @(posedge clk)
    begin
        frame_res_t want;
        if (rst_n && frame_valid && !frame_stall)
        begin
            if (expected_frames.size() == 0)
            begin
                $error("unexpected frame transfer: byte %02h first %0b last %0b discard %0b",
                       frame_byte, first_byte, last_byte, discard);
                fail_count++;
            end
            else
            begin
                want = expected_frames.pop_front();
                if (frame_byte !== want.data)
                begin
                    $error("frame_byte: expected %02h, got %02h", want.data, frame_byte);
                    fail_count++;
                end
                if (first_byte !== want.first)
                begin
                    $error("first_byte: expected %0b, got %0b", want.first, first_byte);
                    fail_count++;
                end
                if (last_byte !== want.last)
                begin
                    $error("last_byte: expected %0b, got %0b", want.last, last_byte);
                    fail_count++;
                end
                if (discard !== want.discard)
                begin
                    $error("discard: expected %0b, got %0b", want.discard, discard);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Byte inside a frame; a data 0xFF goes out as the stuffed pair.
    task automatic push_stuffed(input logic [7:0] b);
        if (b == MARK_BYTE)
        begin
            pending_bytes.push_back(MARK_BYTE);
            pending_bytes.push_back(STUFF_BYTE);
        end
        else
        begin
            pending_bytes.push_back(b);
        end
    endtask

    // Payload byte biased toward the mark and stuff values.
    function automatic logic [7:0] pick_data();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return MARK_BYTE;
        if (r == 1)
            return STUFF_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly well-formed frames with random content, plus noise and broken frames.
    task automatic queue_link_traffic(input int unsigned n_bytes);
        int unsigned kind;
        int unsigned len;
        int unsigned k;
        logic [7:0]  b;
        while (pending_bytes.size() < n_bytes)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 6)
            begin
                len = $urandom_range(1, 12);
                if ($urandom_range(0, 19) == 0)
                    len = 0;
                else if ($urandom_range(0, 39) == 0)
                    len = $urandom_range(256, 300);
                pending_bytes.push_back(MARK_BYTE);
                pending_bytes.push_back(MARK_BYTE);
                push_stuffed(8'(len >> 8));
                push_stuffed(8'(len));
                for (k = 0; k < len; k++)
                    push_stuffed(pick_data());
            end
            else if (kind == 7)
            begin
                // line noise between frames
                k = $urandom_range(1, 4);
                repeat (k) pending_bytes.push_back(pick_data());
            end
            else if (kind == 8)
            begin
                // frame cut short by a bad escape or a fresh header
                pending_bytes.push_back(MARK_BYTE);
                pending_bytes.push_back(MARK_BYTE);
                push_stuffed(8'($urandom_range(0, 255)));
                push_stuffed(8'($urandom_range(0, 255)));
                k = $urandom_range(0, 3);
                repeat (k) push_stuffed(pick_data());
                pending_bytes.push_back(MARK_BYTE);
                if ($urandom_range(0, 1) == 0)
                begin
                    b = 8'($urandom_range(0, 254));
                    if (b == STUFF_BYTE)
                        b = 8'h56;
                    pending_bytes.push_back(b);
                end
                else
                begin
                    pending_bytes.push_back(MARK_BYTE);
                end
            end
            else
            begin
                // three marks in a row: the odd one folds into the header run
                len = $urandom_range(1, 6);
                pending_bytes.push_back(MARK_BYTE);
                pending_bytes.push_back(MARK_BYTE);
                pending_bytes.push_back(MARK_BYTE);
                pending_bytes.push_back(8'h00);
                pending_bytes.push_back(8'(len));
                for (k = 0; k < len; k++)
                    push_stuffed(pick_data());
            end
        end
    endtask

    // Wait until every byte has transferred and every frame transfer has arrived.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || rx_valid || expected_frames.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        logic [7:0] directed[$];
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: hunt noise, a header broken in the middle, a frame with a stuffed
        // body byte, a zero length frame, a stray mark in the length field, a header
        // restarting an open frame, and a frame dropped by a bad escape.
        directed = '{8'h12, 8'hFF, 8'h00,
                     8'hFF, 8'hFF, 8'h00, 8'h02, 8'hAA, 8'hFF, 8'h55,
                     8'hFF, 8'hFF, 8'h00, 8'h00,
                     8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'hFF, 8'hFF,
                     8'h00, 8'h01, 8'hFF, 8'h07};
        foreach (directed[i])
            pending_bytes.push_back(directed[i]);
        wait_drained();

        send_idle_pct = 25;
        recv_stall_pct = 71;
        queue_link_traffic(630);
        wait_drained();

        send_idle_pct = 71;
        recv_stall_pct = 25;
        queue_link_traffic(630);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_link_traffic(630);
        wait_drained();

        if (fail_count == 0 && expected_frames.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
